// ===== hdl/srd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_pkg
// Shared constants and helpers for the sign-magnitude restoring divider.
// ----------------------------------------------------------------------------
package srd_pkg;

	// Default magnitude width of dividend, divisor and integer quotient.
	localparam int MAG_BITS_DEF  = 31;
	// Default number of fractional quotient bits.
	localparam int FRAC_BITS_DEF = 5;

	// Rounds a bit count up to a whole number of bytes.
	function automatic int byte_round(input int nbits);
		return ((nbits + 7) / 8) * 8;
	endfunction

endpackage

// ===== hdl/srd_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_cell
// One restoring division step with its own pipeline register and handshake.
// ----------------------------------------------------------------------------
module srd_cell
	import srd_pkg::*;
#(
	parameter int MAG_BITS  = MAG_BITS_DEF,
	parameter int WORD_BITS = MAG_BITS_DEF + FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_sign,
	input  logic [MAG_BITS-1:0]  in_divisor,
	input  logic [MAG_BITS-1:0]  in_rem,
	input  logic [WORD_BITS-1:0] in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_sign,
	output logic [MAG_BITS-1:0]  out_divisor,
	output logic [MAG_BITS-1:0]  out_rem,
	output logic [WORD_BITS-1:0] out_word
);

	logic                 valid_q;
	logic                 sign_q;
	logic [MAG_BITS-1:0]  divisor_q;
	logic [MAG_BITS-1:0]  rem_q;
	logic [WORD_BITS-1:0] word_q;

	logic [MAG_BITS:0]    shifted;
	logic [MAG_BITS:0]    diff;
	logic                 fits;
	logic [MAG_BITS-1:0]  rem_next;

	// The word carries unused dividend bits at the top and collects quotient
	// bits at the bottom. A remainder left below a nonzero divisor always fits
	// in MAG_BITS; with a zero divisor every bit is one whatever is dropped.
	assign shifted  = {in_rem, in_word[WORD_BITS-1]};
	assign diff     = shifted - {1'b0, in_divisor};
	assign fits     = (shifted >= {1'b0, in_divisor});
	assign rem_next = fits ? diff[MAG_BITS-1:0] : shifted[MAG_BITS-1:0];

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sign_q    <= in_sign;
			divisor_q <= in_divisor;
			rem_q     <= rem_next;
			word_q    <= {in_word[WORD_BITS-2:0], fits};
		end
	end

	assign out_valid   = valid_q;
	assign out_sign    = sign_q;
	assign out_divisor = divisor_q;
	assign out_rem     = rem_q;
	assign out_word    = word_q;

endmodule

// ===== hdl/signmag_restoring_divider_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signmag_restoring_divider_core
// Pipelined sign-magnitude restoring divider built as a row of step cells.
// ----------------------------------------------------------------------------
// Structure: one cell per quotient bit, each with its own pipeline register.
// Throughput: one transaction per cycle while m_axis_tready does not stall the
//   output; each cell holds one operand set and hands it on as soon as the next cell is empty or moving.
// Reset: arst_n clears every cell's valid flag asynchronously; payload
//   registers are not reset. No clearing pass is needed.
// ----------------------------------------------------------------------------
module signmag_restoring_divider_core
	import srd_pkg::*;
#(
	parameter int MAG_BITS  = MAG_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,

	// Operand stream.
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	// tdata, from bit 0 up: dividend_sign, dividend_magnitude,
	// divisor_sign, divisor_magnitude, zero padding to a byte boundary.
	input  logic [byte_round(2*(MAG_BITS+1))-1:0]   s_axis_tdata,

	// Quotient stream.
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	// tdata, from bit 0 up: quotient_sign, quotient_integer,
	// quotient_fraction, zero padding to a byte boundary.
	output logic [byte_round(MAG_BITS+FRAC_BITS+1)-1:0] m_axis_tdata
);

	// Each cell develops one quotient bit, so the word that travels with an
	// operand set is as wide as the whole quotient magnitude.
	localparam int WORD_BITS = MAG_BITS + FRAC_BITS;
	localparam int IN_W      = byte_round(2 * (MAG_BITS + 1));
	localparam int OUT_W     = byte_round(WORD_BITS + 1);

	// Chain taps: index 0 is the input side, index WORD_BITS is the last cell.
	logic [WORD_BITS:0]                valid;
	logic [WORD_BITS:0]                ready;
	logic [WORD_BITS:0]                sign;
	logic [WORD_BITS:0][MAG_BITS-1:0]  divisor;
	logic [WORD_BITS:0][MAG_BITS-1:0]  rem;
	logic [WORD_BITS:0][WORD_BITS-1:0] word;

	logic                 dividend_sign;
	logic [MAG_BITS-1:0]  dividend_magnitude;
	logic                 divisor_sign;
	logic [MAG_BITS-1:0]  divisor_magnitude;

	// Unpack the operand transaction.
	assign dividend_sign      = s_axis_tdata[0];
	assign dividend_magnitude = s_axis_tdata[MAG_BITS:1];
	assign divisor_sign       = s_axis_tdata[MAG_BITS+1];
	assign divisor_magnitude  = s_axis_tdata[2*MAG_BITS+1:MAG_BITS+2];

	// The quotient sign is settled at once and rides along with the operands.
	// The dividend enters the top of the word with zeros below it; those zeros
	// are the bits shifted in while the fractional quotient bits are formed.
	assign valid[0]   = s_axis_tvalid;
	assign sign[0]    = dividend_sign ^ divisor_sign;
	assign divisor[0] = divisor_magnitude;
	assign rem[0]     = '0;
	assign word[0]    = WORD_BITS'(dividend_magnitude) << FRAC_BITS;
	assign s_axis_tready = ready[0];

	for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
		srd_cell #(
			.MAG_BITS  (MAG_BITS),
			.WORD_BITS (WORD_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.in_valid    (valid[i]),
			.in_ready    (ready[i]),
			.in_sign     (sign[i]),
			.in_divisor  (divisor[i]),
			.in_rem      (rem[i]),
			.in_word     (word[i]),
			.out_valid   (valid[i+1]),
			.out_ready   (ready[i+1]),
			.out_sign    (sign[i+1]),
			.out_divisor (divisor[i+1]),
			.out_rem     (rem[i+1]),
			.out_word    (word[i+1])
		);
	end

	// The last cell's register is the output register. Its remainder and
	// divisor are not part of the result.
	assign ready[WORD_BITS] = m_axis_tready;
	assign m_axis_tvalid    = valid[WORD_BITS];

	logic [WORD_BITS:0]     result;
	logic [2*WORD_BITS-1:0] word_pair;
	logic                   unused_tail;

	// The finished word holds the integer bits above the fraction bits, while
	// the bus carries the integer field first. Rotating the word right by the
	// fraction width puts the integer bits at the bottom.
	assign word_pair    = {word[WORD_BITS], word[WORD_BITS]};
	assign result       = {word_pair[FRAC_BITS +: WORD_BITS], sign[WORD_BITS]};
	assign m_axis_tdata = OUT_W'(result);
	assign unused_tail  = ^{rem[WORD_BITS], divisor[WORD_BITS], s_axis_tdata[IN_W-1:0]};

endmodule

// ===== hdl/srd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_checker
// Port-level assertions for the sign-magnitude restoring divider.
// ----------------------------------------------------------------------------
module srd_checker
	import srd_pkg::*;
#(
	parameter int MAG_BITS  = MAG_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic                                        clk,
	input logic                                        arst_n,
	input logic                                        s_axis_tvalid,
	input logic                                        s_axis_tready,
	input logic [byte_round(2*(MAG_BITS+1))-1:0]       s_axis_tdata,
	input logic                                        m_axis_tvalid,
	input logic                                        m_axis_tready,
	input logic [byte_round(MAG_BITS+FRAC_BITS+1)-1:0] m_axis_tdata
);

	localparam int RES_BITS = MAG_BITS + FRAC_BITS + 1;

	// No result is offered while reset is held.
	a_no_result_in_reset: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("result offered during reset");

	// A stalled result stays offered and unchanged.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// The operand side only stalls when every cell is full and the output
	// is blocked.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("operand side stalled with room in the pipeline");

	// Padding bits above the result fields are always zero.
	a_padding_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata >> RES_BITS) == '0)
		else $error("nonzero padding in result");

	logic unused_in;
	assign unused_in = s_axis_tvalid ^ (^s_axis_tdata);

endmodule

bind signmag_restoring_divider_core srd_checker #(
	.MAG_BITS  (MAG_BITS),
	.FRAC_BITS (FRAC_BITS)
) u_srd_checker (.*);
